// ----- design/pepc_pkg.sv -----
// Shared types and codes for the pin event pulse capture block.
package pepc_pkg;

  localparam int PIN_FIELD_W = 4;
  localparam int NOW_W       = 48;
  localparam int WIDTH_W     = 32;
  localparam int ADV_W       = 48;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_MEASURE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [1:0] ST_UNCLAIMED = 2'd2;

  typedef struct packed {
    logic [1:0]             operation;
    logic [PIN_FIELD_W-1:0] pin;
    logic                   level;
    logic [NOW_W-1:0]       now_us;
    logic [NOW_W-1:0]       offset_us;
    logic [WIDTH_W-1:0]     fallback_us;
    logic                   pin_claimed;
  } pepc_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [WIDTH_W-1:0] pulse_width_us;
    logic [ADV_W-1:0]   clock_advance_us;
  } pepc_rsp_t;

endpackage

// ----- design/pepc_sub.sv -----
// Shared subtract and greater-than unit used for all time comparisons.
module pepc_sub #(
  parameter int W = 48
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         gt
);

  logic [W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  // No borrow and a nonzero difference means a is strictly greater.
  assign gt   = !full[W] && (full[W-1:0] != '0);

endmodule

// ----- design/pin_event_pulse_capture.sv -----
// Pin event pulse capture: per-pin level-change queues and pulse measurement.
//
// Usage: drive request and raise start; the command transfers at a rising
// edge where start is high and busy is low. Push stores a level with time
// now_us + offset_us in the addressed pin's circular queue, dropping the oldest
// entry when the queue is full. Clear empties every queue. Measure scans the
// pin's queue for the first entry of the requested level and the next entry
// of the other level, and answers with one result on response, marked by done
// for exactly one cycle; push and clear produce no result.
// Push, clear and rejected measures go straight back to idle. A measure issues
// one memory read per cycle over the pin's queued entries, then uses the shared
// subtractor twice, once for end versus start and once for end versus now.
// done is high in the first cycle that busy is low, and a new command may
// transfer then.
// The receiver cannot stall; each result is shown for one cycle only.
// Reset empties all queues at once; the event memory itself is not cleared.
module pin_event_pulse_capture #(
  parameter int NUM_PINS    = 16,
  parameter int QUEUE_DEPTH = 8,
  parameter int TIME_BITS   = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pepc_pkg::pepc_req_t request,
  output logic               busy,
  output logic               done,
  output pepc_pkg::pepc_rsp_t response
);
  import pepc_pkg::*;

  localparam int PIN_W   = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ADDR_W  = PIN_W + SLOT_W;
  localparam int ENTRY_W = TIME_BITS + 1;
  localparam int SUB_W   = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;
  localparam int WIDE_W  = PIN_FIELD_W + PIN_W;
  localparam logic [SUM_W-1:0] DEPTH_V = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] FULL_V  = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXEC    = 5'b00010,
    S_SCAN    = 5'b00100,
    S_CHECK   = 5'b01000,
    S_ADVANCE = 5'b10000
  } state_t;

  state_t state;
  pepc_req_t req;

  logic [CNT_W-1:0]   cnt  [NUM_PINS];
  logic [SLOT_W-1:0]  head [NUM_PINS];
  logic [ENTRY_W-1:0] mem  [1 << ADDR_W];
  logic [ENTRY_W-1:0] rd_data;

  logic [CNT_W-1:0]   k;
  logic               ev_valid;
  logic               ev_last;
  logic               found_start;
  logic [TIME_BITS-1:0] ts;
  logic [TIME_BITS-1:0] te;
  logic [WIDTH_W-1:0] width_lo;

  // Adds an offset to a queue position, wrapping at the queue depth.
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(offs);
    if (s >= DEPTH_V) begin
      s = s - DEPTH_V;
    end
    return s[SLOT_W-1:0];
  endfunction

  logic [WIDE_W-1:0]    pin_wide;
  logic [PIN_W-1:0]     pin_idx;
  logic                 pin_ok;
  logic [CNT_W-1:0]     cur_cnt;
  logic [SLOT_W-1:0]    cur_head;
  logic                 queue_full;
  logic [SLOT_W-1:0]    push_slot;
  logic [SLOT_W-1:0]    scan_slot;
  logic [64:0]          push_sum;
  logic [TIME_BITS-1:0] push_time;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [CNT_W-1:0]     k_inc;

  assign pin_wide   = WIDE_W'(req.pin);
  assign pin_idx    = pin_wide[PIN_W-1:0];
  assign pin_ok     = {28'd0, req.pin} < 32'(NUM_PINS);
  assign cur_cnt    = cnt[pin_idx];
  assign cur_head   = head[pin_idx];
  assign queue_full = (cur_cnt >= FULL_V);
  assign push_slot  = queue_full ? cur_head : wrap_slot(cur_head, cur_cnt);
  assign scan_slot  = wrap_slot(cur_head, k);
  assign push_sum   = 65'(req.now_us) + 65'(req.offset_us);
  assign push_time  = push_sum[TIME_BITS-1:0];
  assign k_inc      = k + CNT_W'(1);

  assign wr_en   = (state == S_EXEC) && (req.operation == OP_PUSH) && pin_ok;
  assign wr_addr = {pin_idx, push_slot};
  assign rd_addr = {pin_idx, scan_slot};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {req.level, push_time};
    end
    rd_data <= mem[rd_addr];
  end

  // The shared subtractor compares the end time against the start, then now.
  logic [SUB_W-1:0] sub_a;
  logic [SUB_W-1:0] sub_b;
  logic [SUB_W-1:0] sub_diff;
  logic             sub_gt;

  assign sub_a = SUB_W'(te);
  assign sub_b = (state == S_CHECK) ? SUB_W'(ts) : SUB_W'(req.now_us);

  pepc_sub #(.W(SUB_W)) u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .gt   (sub_gt)
  );

  logic                 ev_level;
  logic [TIME_BITS-1:0] ev_time;

  assign ev_level = rd_data[TIME_BITS];
  assign ev_time  = rd_data[TIME_BITS-1:0];
  assign busy     = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      ev_valid <= 1'b0;
      for (int i = 0; i < NUM_PINS; i++) begin
        cnt[i]  <= '0;
        head[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req   <= request;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state       <= S_IDLE;
          k           <= '0;
          ev_valid    <= 1'b0;
          found_start <= 1'b0;
          priority if (req.operation == OP_PUSH) begin
            if (pin_ok) begin
              if (queue_full) begin
                head[pin_idx] <= wrap_slot(cur_head, CNT_W'(1));
              end else begin
                cnt[pin_idx] <= cur_cnt + CNT_W'(1);
              end
            end
          end else if (req.operation == OP_CLEAR) begin
            for (int i = 0; i < NUM_PINS; i++) begin
              cnt[i] <= '0;
            end
          end else if (req.operation == OP_MEASURE) begin
            if (!pin_ok || !req.pin_claimed) begin
              done     <= 1'b1;
              response <= '{status: ST_UNCLAIMED, pulse_width_us: '0,
                             clock_advance_us: '0};
            end else if (cur_cnt == '0) begin
              done     <= 1'b1;
              response <= '{status: ST_TIMEOUT, pulse_width_us: '0,
                             clock_advance_us: ADV_W'(req.fallback_us)};
            end else begin
              state <= S_SCAN;
            end
          end else begin
            // Unused operation codes do nothing.
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          // Issue one read per cycle; the data is examined in the next cycle.
          if (k < cur_cnt) begin
            k <= k_inc;
          end
          ev_valid <= (k < cur_cnt);
          ev_last  <= (k_inc == cur_cnt);
          if (ev_valid) begin
            if (!found_start) begin
              if (ev_level == req.level) begin
                ts          <= ev_time;
                found_start <= 1'b1;
              end
              if (ev_last) begin
                state    <= S_IDLE;
                done     <= 1'b1;
                response <= '{status: ST_TIMEOUT, pulse_width_us: '0,
                               clock_advance_us: ADV_W'(req.fallback_us)};
              end
            end else if (ev_level != req.level) begin
              te    <= ev_time;
              state <= S_CHECK;
            end else if (ev_last) begin
              state    <= S_IDLE;
              done     <= 1'b1;
              response <= '{status: ST_TIMEOUT, pulse_width_us: '0,
                             clock_advance_us: ADV_W'(req.fallback_us)};
            end
          end
        end
        S_CHECK: begin
          if (sub_gt) begin
            width_lo <= sub_diff[WIDTH_W-1:0];
            state    <= S_ADVANCE;
          end else begin
            state    <= S_IDLE;
            done     <= 1'b1;
            response <= '{status: ST_TIMEOUT, pulse_width_us: '0,
                           clock_advance_us: ADV_W'(req.fallback_us)};
          end
        end
        S_ADVANCE: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          cnt[pin_idx] <= '0;
          response     <= '{status: ST_OK, pulse_width_us: width_lo,
                            clock_advance_us: sub_gt ? sub_diff[ADV_W-1:0] : '0};
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/pepc_checker.sv -----
// Port-level checks for the pin event pulse capture block, bound to the top.
module pepc_port_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input pepc_pkg::pepc_rsp_t response
);
  import pepc_pkg::*;

  // A transferred command always raises busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // A result is only shown once the block has finished its work.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe while busy or without prior work");

  // Only a successful measurement reports a width.
  a_width_zero: assert property (@(posedge clk) disable iff (rst)
    done && (response.status != ST_OK) |-> response.pulse_width_us == '0)
    else $error("nonzero width on a failed measurement");

  // A rejected pin never asks for a clock advance.
  a_unclaimed_adv: assert property (@(posedge clk) disable iff (rst)
    done && (response.status == ST_UNCLAIMED) |-> response.clock_advance_us == '0)
    else $error("clock advance reported for an unclaimed pin");

endmodule

bind pin_event_pulse_capture pepc_port_checker u_checker (.*);
